// File: sv/mersenne_twister_generator_macros.svh
// assertion helpers for the generator checker
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// checked only outside reset
`define MTG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

  typedef logic [31:0] word_t;
  typedef logic [9:0]  addr_t;

  // request codes on the func bit
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam addr_t WORD_COUNT = 10'd624;
  localparam addr_t SHIFT_DIST = 10'd397;
  localparam addr_t LAST_ADDR  = 10'd623;
  // WORD_COUNT - SHIFT_DIST, where the far word wraps round
  localparam addr_t WRAP_POINT = 10'd227;

  localparam word_t LCG_MULT   = 32'd69069;
  localparam word_t TWIST_XOR  = 32'h9908B0DF;
  localparam word_t TEMPER_B   = 32'h9D2C5680;
  localparam word_t TEMPER_C   = 32'hEFC60000;
  localparam word_t UPPER_MASK = 32'h80000000;
  localparam word_t LOWER_MASK = 32'h7FFFFFFF;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// File: sv/mtg_if.sv
`default_nettype none
// request channel: func and seed
interface mtg_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  mtg_pkg::word_t    seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

// result channel: one tempered word per draw
interface mtg_out_if;
  logic              valid;
  logic              ready;
  mtg_pkg::word_t    random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

// File: sv/mersenne_twister_generator.sv
// seed word: busy after acceptance while the state fills, no result
// draw word: reads in RDA, RDB and RDC, twist in TW, result to the output register in DONE;
//   the three reads share the single-read state memory; no new request is taken until DONE ends
// draw before any seed: the seeding sweep comes first, then the draw as above
// reset: synchronous active-low rst_n clears control and the seeded flag; the
//   state memory holds no reset value and is only read after a seed
`default_nettype none
module mersenne_twister_generator (
  input  wire       clk,
  input  wire       rst_n,
  mtg_in_if.sink    in_chan,
  mtg_out_if.source out_chan
);
  import mtg_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;  // fill sweep, one word a cycle
  localparam logic [2:0] S_RDA  = 3'd2;  // read word i
  localparam logic [2:0] S_RDB  = 3'd3;  // read word i+1
  localparam logic [2:0] S_RDC  = 3'd4;  // read word i+397 (wrapped)
  localparam logic [2:0] S_TW   = 3'd5;  // twist word i, write back, temper
  localparam logic [2:0] S_DONE = 3'd6;  // hand word to output register

  logic [2:0] state_r, state_nxt;
  logic       seeded_r, seeded_nxt;
  logic       pend_r, pend_nxt;        // draw waiting behind an implicit seed
  addr_t      idx_r, idx_nxt;          // next word to use
  addr_t      sc_r, sc_nxt;            // fill sweep address
  word_t      x_r, x_nxt;              // congruential sequence value
  word_t      a_r, a_nxt;              // word i, old
  word_t      b_r, b_nxt;              // word i+1
  word_t      res_r, res_nxt;          // tempered result
  logic       ov_r, ov_nxt;
  word_t      od_r, od_nxt;

  // state memory
  word_t      mem [WORD_COUNT];
  logic       we;
  addr_t      wa;
  word_t      wd;
  addr_t      ra;
  word_t      rd_q;

  addr_t      idx_p1;
  addr_t      idx_far;
  word_t      y_mix;
  word_t      v_new;
  logic       in_acc;

  assign in_chan.ready        = (state_r == S_IDLE);
  assign in_acc               = in_chan.valid && in_chan.ready;
  assign out_chan.valid       = ov_r;
  assign out_chan.random_word = od_r;

  // neighbours of word i, with wrap round the ring
  assign idx_p1  = (idx_r == LAST_ADDR) ? '0 : idx_r + 10'd1;
  assign idx_far = (idx_r >= WRAP_POINT) ? idx_r - WRAP_POINT : idx_r + SHIFT_DIST;

  // twist in place: for i >= 227 the far word is already this round's, as it should be
  assign y_mix = (a_r & UPPER_MASK) | (b_r & LOWER_MASK);
  assign v_new = rd_q ^ (y_mix >> 1) ^ (b_r[0] ? TWIST_XOR : '0);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_comb begin
    state_nxt  = state_r;
    seeded_nxt = seeded_r;
    pend_nxt   = pend_r;
    idx_nxt    = idx_r;
    sc_nxt     = sc_r;
    x_nxt      = x_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    we         = 1'b0;
    wa         = idx_r;
    wd         = v_new;
    ra         = idx_r;

    // result word taken
    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.func == FUNC_SEED) begin
            x_nxt     = in_chan.seed_value | 32'd1;
            sc_nxt    = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SEED;
          end else if (!seeded_r) begin
            // unseeded draw seeds with one first
            x_nxt     = 32'd1;
            sc_nxt    = '0;
            pend_nxt  = 1'b1;
            state_nxt = S_SEED;
          end else begin
            state_nxt = S_RDA;
          end
        end
      end
      S_SEED: begin
        we     = 1'b1;
        wa     = sc_r;
        wd     = x_r;
        x_nxt  = x_r * LCG_MULT;
        sc_nxt = sc_r + 10'd1;
        if (sc_r == LAST_ADDR) begin
          seeded_nxt = 1'b1;
          idx_nxt    = '0;
          state_nxt  = pend_r ? S_RDA : S_IDLE;
          pend_nxt   = 1'b0;
        end
      end
      S_RDA: begin
        ra        = idx_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        ra        = idx_p1;
        a_nxt     = rd_q;
        state_nxt = S_RDC;
      end
      S_RDC: begin
        ra        = idx_far;
        b_nxt     = rd_q;
        state_nxt = S_TW;
      end
      S_TW: begin
        we        = 1'b1;
        wa        = idx_r;
        wd        = v_new;
        res_nxt   = temper(v_new);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          idx_nxt   = (idx_r == LAST_ADDR) ? '0 : idx_r + 10'd1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      seeded_r <= 1'b0;
      pend_r   <= 1'b0;
      idx_r    <= '0;
      sc_r     <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
      pend_r   <= pend_nxt;
      idx_r    <= idx_nxt;
      sc_r     <= sc_nxt;
      ov_r     <= ov_nxt;
    end
    x_r   <= x_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    od_r  <= od_nxt;
  end

endmodule
`default_nettype wire

// File: sv/mtg_checker.sv
`default_nettype none
`include "mersenne_twister_generator_macros.svh"
module mtg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_func,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_word
);
  import mtg_pkg::*;

  // output register empties on reset
  `MTG_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // the sequencer is busy the cycle after taking a word
  `MTG_ASSERT(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready held after accept")

  // a seed word never makes a result of its own
  `MTG_ASSERT(a_seed_quiet, clk, rst_n, in_valid && in_ready && (in_func == FUNC_SEED) && !out_valid |=> !out_valid, "seed gave a result")

  // stalled result holds
  `MTG_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled result changed")

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_func   (in_chan.func),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.random_word)
);
`default_nettype wire
